[rtl/shfcp_pkg.sv]
// Package for the framed command parser: phase and status codes, protocol
// constants and the frame event record shared by the parser modules.
// Depends on nothing.
`timescale 1ns / 1ps

package shfcp_pkg;

   localparam logic [7:0] HDR_FIRST   = 8'hAA;
   localparam logic [7:0] HDR_SECOND  = 8'h55;
   localparam logic [7:0] FN_RUN      = 8'h01;
   localparam logic [7:0] FN_SPEED    = 8'h10;
   localparam logic [7:0] FN_GAIN     = 8'h11;
   localparam logic [7:0] LEN_SPEED   = 8'd8;
   localparam logic [7:0] LEN_GAIN    = 8'd12;

   localparam int MAX_PAYLOAD = 32;
   localparam int CMD_BYTES   = 12;
   localparam int CMD_IDX_W   = $clog2(CMD_BYTES);

   typedef logic [CMD_BYTES-1:0][7:0] cmd_bytes_type;

   typedef enum logic [2:0] {
      PH_HUNT1   = 3'd0,
      PH_HUNT2   = 3'd1,
      PH_FUNC    = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_SUM     = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_APPLIED  = 2'd0,
      ST_IGNORED  = 2'd1,
      ST_BAD_SUM  = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      logic       too_long;
      logic       sum_ok;
      logic [7:0] func;
      logic [7:0] len;
   } frame_event_type;

endpackage

[rtl/shfcp_framer.sv]
// Frame parser: header hunt, function and length capture, payload store and
// running checksum. Reports a frame event for each finished or aborted frame.
// Depends on shfcp_pkg.
`timescale 1ns / 1ps

module shfcp_framer
   import shfcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  logic [7:0]      rx_data,
   output frame_event_type frame_event,
   output cmd_bytes_type   cmd_bytes
);

   phase_type     phase_ff, phase_in;
   logic [7:0]    func_ff, func_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    count_next;
   logic          store_en;
   cmd_bytes_type bytes_ff;

   assign count_next = count_ff + 8'd1;

   always_comb begin
      case (phase_ff)
         PH_HUNT2: begin
            if (rx_data == HDR_SECOND) begin
               phase_in = PH_FUNC;
            end else if (rx_data == HDR_FIRST) begin
               phase_in = PH_HUNT2;
            end else begin
               phase_in = PH_HUNT1;
            end
         end
         PH_FUNC: begin
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            if (rx_data == 8'd0) begin
               phase_in = PH_SUM;
            end else if (rx_data > 8'(MAX_PAYLOAD)) begin
               phase_in = PH_HUNT1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            phase_in = (count_next >= len_ff) ? PH_SUM : PH_PAYLOAD;
         end
         PH_SUM: begin
            phase_in = PH_HUNT1;
         end
         default: begin
            phase_in = (rx_data == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
         end
      endcase
   end

   always_comb begin
      func_in     = func_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      store_en    = 1'b0;
      frame_event = '0;
      frame_event.func = func_ff;
      frame_event.len  = len_ff;
      case (phase_ff)
         PH_HUNT2: begin
            if (rx_data == HDR_SECOND) begin
               sum_in = 8'd0;
            end
         end
         PH_FUNC: begin
            func_in = rx_data;
            sum_in  = sum_ff + rx_data;
         end
         PH_LEN: begin
            len_in   = rx_data;
            sum_in   = sum_ff + rx_data;
            count_in = 8'd0;
            if (rx_data > 8'(MAX_PAYLOAD)) begin
               frame_event.valid    = 1'b1;
               frame_event.too_long = 1'b1;
               frame_event.len      = rx_data;
            end
         end
         PH_PAYLOAD: begin
            store_en = (count_ff < 8'(CMD_BYTES));
            count_in = count_next;
            sum_in   = sum_ff + rx_data;
         end
         PH_SUM: begin
            frame_event.valid  = 1'b1;
            frame_event.sum_ok = (sum_ff == rx_data);
         end
         default: begin
            frame_event.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         func_ff  <= 8'd0;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
         sum_ff   <= 8'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         func_ff  <= func_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_en) begin
         bytes_ff[count_ff[CMD_IDX_W-1:0]] <= rx_data;
      end
   end

   assign cmd_bytes = bytes_ff;

`ifndef NO_ASSERTIONS
   a_count_below_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_ff < len_ff))
      else $error("payload count reached the frame length while still in payload");

   a_sum_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (fire && phase_ff == PH_SUM) |=> (phase_ff == PH_HUNT1))
      else $error("checksum byte did not return the parser to hunting");

   a_long_len_aborts: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN && rx_data > 8'(MAX_PAYLOAD))
         |-> (frame_event.valid && frame_event.too_long))
      else $error("oversized length did not raise an abort event");
`endif

endmodule

[rtl/shfcp_cmd_regs.sv]
// Command decode and the run, speed and gain registers it updates.
// Turns a frame event into a status code. Depends on shfcp_pkg.
`timescale 1ns / 1ps

module shfcp_cmd_regs
   import shfcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  frame_event_type frame_event,
   input  cmd_bytes_type   cmd_bytes,
   output status_type      status,
   output logic [7:0]      run_flag,
   output logic [31:0]     speed_left_bits,
   output logic [31:0]     speed_right_bits,
   output logic [31:0]     gain_p_bits,
   output logic [31:0]     gain_i_bits,
   output logic [31:0]     gain_d_bits
);

   logic        good_frame;
   logic        do_run, do_speed, do_gain;
   logic [7:0]  run_ff;
   logic [31:0] speed_l_ff, speed_r_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic [31:0] word0, word1, word2;

   assign word0 = {cmd_bytes[3], cmd_bytes[2], cmd_bytes[1], cmd_bytes[0]};
   assign word1 = {cmd_bytes[7], cmd_bytes[6], cmd_bytes[5], cmd_bytes[4]};
   assign word2 = {cmd_bytes[11], cmd_bytes[10], cmd_bytes[9], cmd_bytes[8]};

   assign good_frame = frame_event.valid && !frame_event.too_long && frame_event.sum_ok;
   assign do_run   = good_frame && frame_event.func == FN_RUN && frame_event.len != 8'd0;
   assign do_speed = good_frame && frame_event.func == FN_SPEED
                     && frame_event.len == LEN_SPEED;
   assign do_gain  = good_frame && frame_event.func == FN_GAIN
                     && frame_event.len == LEN_GAIN;

   always_comb begin
      if (frame_event.too_long) begin
         status = ST_TOO_LONG;
      end else if (!frame_event.sum_ok) begin
         status = ST_BAD_SUM;
      end else if (do_run || do_speed || do_gain) begin
         status = ST_APPLIED;
      end else begin
         status = ST_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 8'd0;
         speed_l_ff <= 32'd0;
         speed_r_ff <= 32'd0;
         gain_p_ff  <= 32'd0;
         gain_i_ff  <= 32'd0;
         gain_d_ff  <= 32'd0;
      end else if (fire) begin
         if (do_run) begin
            run_ff <= cmd_bytes[0];
         end
         if (do_speed) begin
            speed_l_ff <= word0;
            speed_r_ff <= word1;
         end
         if (do_gain) begin
            gain_p_ff <= word0;
            gain_i_ff <= word1;
            gain_d_ff <= word2;
         end
      end
   end

   assign run_flag         = run_ff;
   assign speed_left_bits  = speed_l_ff;
   assign speed_right_bits = speed_r_ff;
   assign gain_p_bits      = gain_p_ff;
   assign gain_i_bits      = gain_i_ff;
   assign gain_d_bits      = gain_d_ff;

endmodule

[rtl/sync_header_frame_command_parser.sv]
// Top level of the framed command parser: request handshake, result register
// and the two parser stages. Depends on shfcp_pkg, shfcp_framer, shfcp_cmd_regs.
//
//   Channel   Direction  Payload                                   Handshake
//   req_      in         rx_data (8 bits)                          req_valid/req_ready
//   rsp_      out        status, func_code, run_flag, speed/gain   rsp_valid/rsp_ready
//
// One byte is taken per cycle while req_ready is high; a result shows in the cycle after the byte that ends a frame.
// The parser registers and the result register are the only stages.
// Reset returns the parser to header hunting and clears the run, speed and gain words.
// While a result waits and rsp_ready is low, req_ready is low and no byte is taken.
`timescale 1ns / 1ps

module sync_header_frame_command_parser
   import shfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_func_code,
   output logic [7:0]  rsp_run_flag,
   output logic [31:0] rsp_speed_left_bits,
   output logic [31:0] rsp_speed_right_bits,
   output logic [31:0] rsp_gain_p_bits,
   output logic [31:0] rsp_gain_i_bits,
   output logic [31:0] rsp_gain_d_bits
);

   logic            fire;
   frame_event_type frame_event;
   cmd_bytes_type   cmd_bytes;
   status_type      status;
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      status_ff;
   logic [7:0]      func_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   shfcp_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .rx_data     (req_rx_data),
      .frame_event (frame_event),
      .cmd_bytes   (cmd_bytes)
   );

   shfcp_cmd_regs u_cmd_regs (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .frame_event      (frame_event),
      .cmd_bytes        (cmd_bytes),
      .status           (status),
      .run_flag         (rsp_run_flag),
      .speed_left_bits  (rsp_speed_left_bits),
      .speed_right_bits (rsp_speed_right_bits),
      .gain_p_bits      (rsp_gain_p_bits),
      .gain_i_bits      (rsp_gain_i_bits),
      .gain_d_bits      (rsp_gain_d_bits)
   );

   always_comb begin
      if (fire && frame_event.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && frame_event.valid) begin
         status_ff <= status;
         func_ff   <= frame_event.func;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_func_code = func_ff;

endmodule

[sim/command_frame_checker.sv]
// Checker for the framed command parser: follows every accepted request byte through its own
// parser model, queues the frame outcomes it predicts and compares them with the results.
// Depends on shfcp_pkg for the protocol constants, phase codes and status codes.
`timescale 1ns / 1ps

module command_frame_checker
   import shfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_func_code,
   input  logic [7:0]  rsp_run_flag,
   input  logic [31:0] rsp_speed_left_bits,
   input  logic [31:0] rsp_speed_right_bits,
   input  logic [31:0] rsp_gain_p_bits,
   input  logic [31:0] rsp_gain_i_bits,
   input  logic [31:0] rsp_gain_d_bits,
   output int          fail_count,
   output int          pending,
   output int          results_checked,
   output int          applied_seen
);

   typedef struct packed {
      status_type  status;
      logic [7:0]  func;
      logic [7:0]  run;
      logic [31:0] speed_l;
      logic [31:0] speed_r;
      logic [31:0] gain_p;
      logic [31:0] gain_i;
      logic [31:0] gain_d;
   } frame_outcome_type;

   frame_outcome_type outcome_q[$];

   phase_type   cur_phase;
   logic [7:0]  cur_func;
   logic [7:0]  cur_len;
   logic [7:0]  pay_index;
   logic [7:0]  frame_sum;
   logic [7:0]  payload_bytes [MAX_PAYLOAD];
   logic [7:0]  run_reg;
   logic [31:0] speed_reg [2];
   logic [31:0] gain_reg [3];
   int          mismatches = 0;
   int          results = 0;
   int          applied = 0;

   function automatic logic [31:0] le_word(input int base);
      return {payload_bytes[base + 3], payload_bytes[base + 2],
              payload_bytes[base + 1], payload_bytes[base]};
   endfunction

   function automatic void post_outcome(input status_type st);
      frame_outcome_type o;
      o.status  = st;
      o.func    = cur_func;
      o.run     = run_reg;
      o.speed_l = speed_reg[0];
      o.speed_r = speed_reg[1];
      o.gain_p  = gain_reg[0];
      o.gain_i  = gain_reg[1];
      o.gain_d  = gain_reg[2];
      outcome_q.push_back(o);
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      case (cur_phase)
         PH_HUNT2: begin
            if (b == HDR_SECOND) begin
               cur_phase = PH_FUNC;
               frame_sum = 8'd0;
            end else if (b != HDR_FIRST) begin
               cur_phase = PH_HUNT1;
            end
         end
         PH_FUNC: begin
            cur_func  = b;
            frame_sum = frame_sum + b;
            cur_phase = PH_LEN;
         end
         PH_LEN: begin
            cur_len   = b;
            frame_sum = frame_sum + b;
            if (b == 8'd0) begin
               cur_phase = PH_SUM;
            end else if (b > MAX_PAYLOAD) begin
               cur_phase = PH_HUNT1;
               post_outcome(ST_TOO_LONG);
            end else begin
               pay_index = 8'd0;
               cur_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (pay_index < MAX_PAYLOAD) payload_bytes[pay_index] = b;
            pay_index = pay_index + 8'd1;
            frame_sum = frame_sum + b;
            if (pay_index >= cur_len) cur_phase = PH_SUM;
         end
         PH_SUM: begin
            if (frame_sum != b) begin
               post_outcome(ST_BAD_SUM);
            end else if (cur_func == FN_RUN && cur_len >= 8'd1) begin
               run_reg = payload_bytes[0];
               post_outcome(ST_APPLIED);
            end else if (cur_func == FN_SPEED && cur_len == LEN_SPEED) begin
               speed_reg[0] = le_word(0);
               speed_reg[1] = le_word(4);
               post_outcome(ST_APPLIED);
            end else if (cur_func == FN_GAIN && cur_len == LEN_GAIN) begin
               gain_reg[0] = le_word(0);
               gain_reg[1] = le_word(4);
               gain_reg[2] = le_word(8);
               post_outcome(ST_APPLIED);
            end else begin
               post_outcome(ST_IGNORED);
            end
            cur_phase = PH_HUNT1;
         end
         default: begin
            if (b == HDR_FIRST) cur_phase = PH_HUNT2;
            else cur_phase = PH_HUNT1;
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      frame_outcome_type want;
      if (reset) begin
         cur_phase    = PH_HUNT1;
         cur_func     = 8'd0;
         cur_len      = 8'd0;
         pay_index    = 8'd0;
         frame_sum    = 8'd0;
         run_reg      = 8'd0;
         speed_reg[0] = 32'd0;
         speed_reg[1] = 32'd0;
         gain_reg[0]  = 32'd0;
         gain_reg[1]  = 32'd0;
         gain_reg[2]  = 32'd0;
         outcome_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: status %0d, function %h",
                           rsp_status, rsp_func_code);
            end else begin
               want = outcome_q.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("func_code", 32'(want.func), 32'(rsp_func_code));
               compare_field("run_flag", 32'(want.run), 32'(rsp_run_flag));
               compare_field("speed_left", want.speed_l, rsp_speed_left_bits);
               compare_field("speed_right", want.speed_r, rsp_speed_right_bits);
               compare_field("gain_p", want.gain_p, rsp_gain_p_bits);
               compare_field("gain_i", want.gain_i, rsp_gain_i_bits);
               compare_field("gain_d", want.gain_d, rsp_gain_d_bits);
               results++;
               if (want.status == ST_APPLIED) applied++;
            end
         end
         if (req_valid && req_ready) parse_byte(req_rx_data);
      end
      fail_count      <= mismatches;
      pending         <= outcome_q.size();
      results_checked <= results;
      applied_seen    <= applied;
   end

endmodule

[sim/tb.sv]
// Testbench top for the framed command parser: clock, reset, byte stream and result
// acceptance with random stalls, watchdog and verdict. Depends on shfcp_pkg,
// sync_header_frame_command_parser and command_frame_checker.
`timescale 1ns / 1ps

module tb
   import shfcp_pkg::*;
();

   localparam int LONG_HOLD   = 150;
   localparam int IDLE_LIMIT  = 1000;
   localparam int BYTE_TARGET = 1650;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_func_code;
   logic [7:0]  rsp_run_flag;
   logic [31:0] rsp_speed_left_bits;
   logic [31:0] rsp_speed_right_bits;
   logic [31:0] rsp_gain_p_bits;
   logic [31:0] rsp_gain_i_bits;
   logic [31:0] rsp_gain_d_bits;

   int fail_count;
   int pending;
   int results_checked;
   int applied_seen;
   int idle_cycles = 0;
   int frame_bytes = 0;
   int frames = 0;
   bit quiet = 1'b0;
   bit hold_rsp = 1'b0;

   always #6 clock = ~clock;

   sync_header_frame_command_parser i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_data          (req_rx_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_func_code        (rsp_func_code),
      .rsp_run_flag         (rsp_run_flag),
      .rsp_speed_left_bits  (rsp_speed_left_bits),
      .rsp_speed_right_bits (rsp_speed_right_bits),
      .rsp_gain_p_bits      (rsp_gain_p_bits),
      .rsp_gain_i_bits      (rsp_gain_i_bits),
      .rsp_gain_d_bits      (rsp_gain_d_bits)
   );

   command_frame_checker i_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_data          (req_rx_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_func_code        (rsp_func_code),
      .rsp_run_flag         (rsp_run_flag),
      .rsp_speed_left_bits  (rsp_speed_left_bits),
      .rsp_speed_right_bits (rsp_speed_right_bits),
      .rsp_gain_p_bits      (rsp_gain_p_bits),
      .rsp_gain_i_bits      (rsp_gain_i_bits),
      .rsp_gain_d_bits      (rsp_gain_d_bits),
      .fail_count           (fail_count),
      .pending              (pending),
      .results_checked      (results_checked),
      .applied_seen         (applied_seen)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_data <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame(input logic [7:0] fn, input logic [7:0] ln, input bit bad_sum,
                             input int extra_aa, input int fill);
      logic [7:0] sum;
      logic [7:0] b;
      int         k;
      sum = fn + ln;
      push_byte(HDR_FIRST);
      repeat (extra_aa) push_byte(HDR_FIRST);
      push_byte(HDR_SECOND);
      push_byte(fn);
      push_byte(ln);
      frame_bytes += 4 + extra_aa;
      if (ln <= MAX_PAYLOAD) begin
         for (k = 0; k < ln; k++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b;
            push_byte(b);
         end
         if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
         push_byte(sum);
         frame_bytes += ln + 1;
      end
      frames++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : rsp_side
      int n;
      repeat (12) @(posedge clock);
      rsp_ready <= 1'b1;
      @(posedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (n > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (n - 1) @(posedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int         pick;
      int         aa;
      bit         bad;
      logic [7:0] fn;
      logic [7:0] ln;
      logic [7:0] junk;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      push_byte(8'h00);
      push_byte(8'hFF);
      send_frame(FN_RUN, 8'd0, 1'b0, 1, -1);
      send_frame(FN_RUN, 8'd1, 1'b0, 0, 8'hFF);
      send_frame(8'hFF, 8'hFF, 1'b0, 0, -1);
      send_frame(FN_SPEED, LEN_SPEED, 1'b0, 0, 8'hFF);
      drain_results();

      while (frame_bytes < BYTE_TARGET) begin
         quiet = (frames >= 60 && frames < 85);
         if (frames == 30) hold_rsp = 1'b1;
         if (frames == 110) drain_results();
         pick = $urandom_range(0, 99);
         bad  = ($urandom_range(0, 9) == 0);
         aa   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
         if (pick < 25) begin
            send_frame(FN_SPEED, LEN_SPEED, bad, aa, -1);
         end else if (pick < 45) begin
            send_frame(FN_GAIN, LEN_GAIN, bad, aa, -1);
         end else if (pick < 58) begin
            ln = ($urandom_range(0, 3) == 0) ? 8'(MAX_PAYLOAD)
                                             : 8'($urandom_range(1, MAX_PAYLOAD));
            send_frame(FN_RUN, ln, bad, aa, -1);
         end else if (pick < 78) begin
            case ($urandom_range(0, 3))
               0:       fn = FN_RUN;
               1:       fn = FN_SPEED;
               2:       fn = FN_GAIN;
               default: fn = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       ln = 8'd0;
               1:       ln = 8'($urandom_range(0, MAX_PAYLOAD));
               2:       ln = LEN_SPEED - 8'd1 + 8'($urandom_range(0, 2));
               default: ln = LEN_GAIN - 8'd1 + 8'($urandom_range(0, 2));
            endcase
            send_frame(fn, ln, bad, aa, -1);
         end else if (pick < 86) begin
            send_frame(8'($urandom), 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0, aa, -1);
         end else if (pick < 93) begin
            junk = 8'($urandom);
            if (junk == HDR_SECOND) junk = junk + 8'd1;
            push_byte(HDR_FIRST);
            push_byte(junk);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               junk = ($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom);
               if (junk == HDR_SECOND) junk = junk + 8'd1;
               push_byte(junk);
            end
         end
      end
      quiet = 1'b0;
      drain_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d frame bytes in %0d frames, with header noise, a long result stall",
               frame_bytes, frames);
      $display("and drained pauses; checked %0d results, %0d of them applied commands.",
               results_checked, applied_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
